>>> hw/rtl/esr_pkg.sv
// Shared constants and types of the event sequence recorder.
package esr_pkg;

    // Circular event store
    localparam int DEPTH   = 32;
    localparam int PTR_W   = $clog2(DEPTH);
    // Pending count and read request width, as seen on the ports
    localparam int CNT_W   = 6;
    // Most records a single read transaction may return
    localparam int MAX_OUT = 32;

    // Command queue between front and back end
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Payload field widths
    localparam int IDX_W   = 8;
    localparam int ST_W    = 8;
    localparam int SEC_W   = 32;
    localparam int MS_W    = 10;

    // Command codes
    typedef enum logic {
        CMD_RECORD = 1'b0,
        CMD_READ   = 1'b1
    } t_cmd_code;

    // One stored event
    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [ST_W-1:0]  state;
        logic [SEC_W-1:0] seconds;
        logic [MS_W-1:0]  millis;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Classified command as it travels through the queue
    typedef struct packed {
        t_cmd_code        code;
        t_entry           entry;
        logic [CNT_W-1:0] want;   // read request, already clipped to MAX_OUT
    } t_cmd;

    // Handshake between queue and back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_out;

    // Back end sequencer states
    typedef enum logic {
        BK_IDLE,
        BK_FETCH
    } t_back_state;

endpackage

>>> hw/rtl/esr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module esr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/esr_front.sv
// Front end: accepts input transactions and classifies them into queue commands.
module esr_front (
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_command,
    input  logic [esr_pkg::IDX_W-1:0] i_event_index,
    input  logic [esr_pkg::ST_W-1:0]  i_event_state,
    input  logic [esr_pkg::SEC_W-1:0] i_seconds,
    input  logic [esr_pkg::MS_W-1:0]  i_millis,
    input  logic [esr_pkg::CNT_W-1:0] i_read_count,
    output logic                      o_push,
    input  logic                      i_q_full,
    output esr_pkg::t_cmd             o_cmd
);
    import esr_pkg::*;

    localparam logic [CNT_W-1:0] MaxOutC = CNT_W'(MAX_OUT);

    // Accept whenever the queue has room
    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // Classify: decode the command, pack the event, clip the read request
    always_comb begin
        o_cmd               = '0;
        o_cmd.code          = i_command ? CMD_READ : CMD_RECORD;
        o_cmd.entry.index   = i_event_index;
        o_cmd.entry.state   = i_event_state;
        o_cmd.entry.seconds = i_seconds;
        o_cmd.entry.millis  = i_millis;
        o_cmd.want          = (i_read_count > MaxOutC) ? MaxOutC : i_read_count;
    end

endmodule

>>> hw/rtl/esr_queue.sv
// Short command queue that decouples the front end from the back end.
module esr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  esr_pkg::t_cmd   i_cmd,
    output logic            o_full,
    output esr_pkg::t_q_out o_head,
    input  logic            i_pop
);
    import esr_pkg::*;

    localparam logic [QPTR_W-1:0] LastPtr = QPTR_W'(QDEPTH - 1);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_head, n_head;
    logic [QPTR_W-1:0] r_tail, n_tail;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_head];

    // Pointer and occupancy updates
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (do_push) begin
            n_tail = (r_tail == LastPtr) ? '0 : r_tail + 1'b1;
        end
        if (do_pop) begin
            n_head = (r_head == LastPtr) ? '0 : r_head + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Payload storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_tail] <= i_cmd;
        end
    end

endmodule

>>> hw/rtl/esr_back.sv
// Back end: executes record and read commands against the event store.
module esr_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  esr_pkg::t_q_out           i_head,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_has_record,
    output logic [esr_pkg::IDX_W-1:0] o_out_index,
    output logic [esr_pkg::ST_W-1:0]  o_out_state,
    output logic [esr_pkg::SEC_W-1:0] o_out_seconds,
    output logic [esr_pkg::MS_W-1:0]  o_out_millis,
    output logic [esr_pkg::CNT_W-1:0] o_pending,
    output logic                      o_overflow,
    output logic                      o_last
);
    import esr_pkg::*;

    localparam logic [CNT_W-1:0] DepthC   = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LastAddr = PTR_W'(DEPTH - 1);

    t_back_state       r_state, n_state;
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [CNT_W-1:0]  r_pend, n_pend;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_remain, n_remain;
    logic [CNT_W-1:0]  r_after, n_after;

    // Output register
    logic              r_ov, n_ov;
    logic              r_has, n_has;
    t_entry            r_ent, n_ent;
    logic [CNT_W-1:0]  r_opend, n_opend;
    logic              r_ovf, n_ovf;
    logic              r_last, n_last;

    // RAM port
    logic              ram_we, ram_re;
    logic [PTR_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry            rd_entry;

    logic              slot_free;
    logic              start;
    logic              is_read;
    logic              full;
    logic [CNT_W-1:0]  take;
    logic [PTR_W:0]    pos_sum;
    logic [PTR_W-1:0]  pos;

    assign slot_free = !r_ov || i_out_ready;
    assign start     = (r_state == BK_IDLE) && i_head.valid && slot_free;
    assign o_pop     = start;
    assign is_read   = (i_head.cmd.code == CMD_READ);
    assign full      = (r_pend == DepthC);
    assign rd_entry  = t_entry'(ram_rdata);

    // Records to emit: request clipped to pending count
    assign take = (i_head.cmd.want < r_pend) ? i_head.cmd.want : r_pend;

    // Oldest pending slot: write pointer minus pending count, modulo DEPTH
    assign pos_sum = {1'b0, r_wp} + (PTR_W+1)'(DEPTH) - (PTR_W+1)'(r_pend);
    assign pos     = (pos_sum >= (PTR_W+1)'(DEPTH)) ?
                     PTR_W'(pos_sum - (PTR_W+1)'(DEPTH)) : PTR_W'(pos_sum);

    assign ram_we = start && !is_read;

    esr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (ENTRY_W'(i_head.cmd.entry)),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (start && is_read && (take != '0)) begin
                    n_state = BK_FETCH;
                end
            end
            BK_FETCH: begin
                if (slot_free && (r_remain == CNT_W'(1))) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // Datapath and outputs of the sequencer
    always_comb begin
        n_wp      = r_wp;
        n_pend    = r_pend;
        n_rd_ptr  = r_rd_ptr;
        n_remain  = r_remain;
        n_after   = r_after;
        n_ov      = slot_free ? 1'b0 : r_ov;
        n_has     = r_has;
        n_ent     = r_ent;
        n_opend   = r_opend;
        n_ovf     = r_ovf;
        n_last    = r_last;
        ram_re    = 1'b0;
        ram_raddr = pos;
        unique case (r_state)
            BK_IDLE: begin
                if (start) begin
                    n_ov  = 1'b1;
                    n_has = 1'b0;
                    n_ent = '0;
                    n_ovf = 1'b0;
                    n_last = 1'b1;
                    n_opend = r_pend;
                    if (!is_read) begin
                        // Record: store at write pointer, bump or saturate pending
                        n_wp    = (r_wp == LastAddr) ? '0 : r_wp + 1'b1;
                        n_pend  = full ? r_pend : r_pend + 1'b1;
                        n_opend = n_pend;
                        n_ovf   = full;
                    end else if (take != '0) begin
                        // Read: fetch first record into the RAM read register
                        n_ov     = 1'b0;
                        ram_re   = 1'b1;
                        ram_raddr = pos;
                        n_rd_ptr = (pos == LastAddr) ? '0 : pos + 1'b1;
                        n_remain = take;
                        n_after  = r_pend - take;
                        n_pend   = r_pend - take;
                    end
                end
            end
            BK_FETCH: begin
                ram_raddr = r_rd_ptr;
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_has   = 1'b1;
                    n_ent   = rd_entry;
                    n_opend = r_after;
                    n_ovf   = 1'b0;
                    n_last  = (r_remain == CNT_W'(1));
                    if (r_remain != CNT_W'(1)) begin
                        ram_re   = 1'b1;
                        n_rd_ptr = (r_rd_ptr == LastAddr) ? '0 : r_rd_ptr + 1'b1;
                        n_remain = r_remain - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_wp    <= '0;
            r_pend  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_pend  <= n_pend;
            r_ov    <= n_ov;
        end
    end

    // Payload and iteration registers
    always_ff @(posedge i_clk) begin
        r_rd_ptr <= n_rd_ptr;
        r_remain <= n_remain;
        r_after  <= n_after;
        r_has    <= n_has;
        r_ent    <= n_ent;
        r_opend  <= n_opend;
        r_ovf    <= n_ovf;
        r_last   <= n_last;
    end

    assign o_out_valid   = r_ov;
    assign o_has_record  = r_has;
    assign o_out_index   = r_ent.index;
    assign o_out_state   = r_ent.state;
    assign o_out_seconds = r_ent.seconds;
    assign o_out_millis  = r_ent.millis;
    assign o_pending     = r_opend;
    assign o_overflow    = r_ovf;
    assign o_last        = r_last;

endmodule

>>> hw/rtl/event_sequence_recorder.sv
// Event sequence recorder: timestamped 32-entry circular event log.
//
// A record transaction (command 0) stores index, state and seconds/millis time
// in a 32-entry circular store, overwriting the oldest entry when full, and
// returns one result with the pending count (overflow set if an unread entry
// was lost). A read transaction (command 1) returns the oldest pending records
// in order, at most read_count and never more than 32, with last set on the
// final one; a read with nothing to give returns one empty result. Inputs are
// taken into a two-entry command queue, so the input side can still accept
// commands while a result waits on the output, until the queue is full. The
// back end retires a record command straight from idle; a read first waits on
// the registered read port of the event store, after which one record leaves
// per cycle while the output is ready.
module event_sequence_recorder (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_command,
    input  logic [esr_pkg::IDX_W-1:0] i_event_index,
    input  logic [esr_pkg::ST_W-1:0]  i_event_state,
    input  logic [esr_pkg::SEC_W-1:0] i_seconds,
    input  logic [esr_pkg::MS_W-1:0]  i_millis,
    input  logic [esr_pkg::CNT_W-1:0] i_read_count,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_has_record,
    output logic [esr_pkg::IDX_W-1:0] o_out_index,
    output logic [esr_pkg::ST_W-1:0]  o_out_state,
    output logic [esr_pkg::SEC_W-1:0] o_out_seconds,
    output logic [esr_pkg::MS_W-1:0]  o_out_millis,
    output logic [esr_pkg::CNT_W-1:0] o_pending,
    output logic                      o_overflow,
    output logic                      o_last
);
    import esr_pkg::*;

    logic   push;
    logic   q_full;
    logic   pop;
    t_cmd   cmd;
    t_q_out q_head;

    esr_front u_front (
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_event_index (i_event_index),
        .i_event_state (i_event_state),
        .i_seconds     (i_seconds),
        .i_millis      (i_millis),
        .i_read_count  (i_read_count),
        .o_push        (push),
        .i_q_full      (q_full),
        .o_cmd         (cmd)
    );

    esr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .o_full  (q_full),
        .o_head  (q_head),
        .i_pop   (pop)
    );

    esr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (q_head),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_has_record  (o_has_record),
        .o_out_index   (o_out_index),
        .o_out_state   (o_out_state),
        .o_out_seconds (o_out_seconds),
        .o_out_millis  (o_out_millis),
        .o_pending     (o_pending),
        .o_overflow    (o_overflow),
        .o_last        (o_last)
    );

endmodule

>>> hw/rtl/esr_checker.sv
// Port-level assertions for the event sequence recorder, bound to the top level.
module esr_props (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic                      i_has_record,
    input logic [esr_pkg::SEC_W-1:0] i_out_seconds,
    input logic [esr_pkg::CNT_W-1:0] i_pending,
    input logic                      i_overflow,
    input logic                      i_last
);
    import esr_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_seconds) && $stable(i_pending) && $stable(i_last))
        else $error("result changed while stalled");

    // A result without a record always closes its transaction
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_has_record |-> i_last)
        else $error("empty result not marked last");

    // Overflow only on a record answer with the store full
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_overflow |-> !i_has_record && (i_pending == CNT_W'(DEPTH)))
        else $error("overflow without a full store");

    // Records of one read share the same pending count
    a_read_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_last) ##1 i_out_valid |->
            i_has_record && (i_pending == $past(i_pending)))
        else $error("pending count changed within a read");

endmodule

bind event_sequence_recorder esr_props u_esr_props (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .i_has_record  (o_has_record),
    .i_out_seconds (o_out_seconds),
    .i_pending     (o_pending),
    .i_overflow    (o_overflow),
    .i_last        (o_last)
);
